### rtl/gdj_pkg.sv
// Shared constants, types and calendar tables for the date / day number converter.
package gdj_pkg;

    // Field widths
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned JDN_W   = 23;

    // Pipeline depths: core stages, date path compute stages, total to the outputs
    localparam int unsigned PIPE_LAT = 9;
    localparam int unsigned D2J_LAT  = 5;
    localparam int unsigned D2J_PAD  = PIPE_LAT - D2J_LAT;
    localparam int unsigned LATENCY  = PIPE_LAT + 2;

    localparam int unsigned MONTHS = 12;

    // Supported day number range (0001-01-01 to 9999-12-31)
    localparam logic [JDN_W-1:0] JDN_MIN = 23'd1721426;
    localparam logic [JDN_W-1:0] JDN_MAX = 23'd5373484;

    // Request codes
    localparam logic REQ_D2J = 1'b0;
    localparam logic REQ_J2D = 1'b1;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 43699
    localparam logic [12:0] RECIP100_MUL = 13'd5243;
    localparam int unsigned RECIP100_SH  = 19;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // Days from 1 March to the first day of the March-based month mm
    function automatic logic [8:0] f_days_before(input logic [3:0] mm);
        logic [8:0] days;
        case (mm)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // Length of a calendar month, zero for a month number outside 1..12
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### rtl/gregorian_date_jdn_converter_top.sv
// Proleptic Gregorian date <-> Julian Day Number converter, fully pipelined.
// Request channel: drive i_req_type and the operands with start high; a beat is taken at
// every rising edge where start is high and busy is low. busy stays low, so a request
// may be issued in every clock cycle.
// i_req_type selects the direction: date to day number reads i_year_in, i_month_in and
// i_day_in; day number to date reads i_jdn_in. The other operands are ignored.
// Result channel: o_strobe marks each result beat for exactly one cycle, in request
// order; throughput is one result per cycle. A request passes through the nine stages
// of the day-number-to-date path (two reciprocal multiplies, each with a correcting
// subtract, then a month search), which the date path is padded to match, then two
// shared stages for leap year, month length and validity checks.
// The receiver cannot hold results off: each beat must be taken in its strobe cycle.
// Synchronous reset (i_rst_n low) empties the pipeline: no result issues for a request
// taken before reset. Payload outputs are not reset.
module gregorian_date_jdn_converter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [gdj_pkg::YEAR_W-1:0]  i_year_in,
    input  logic [gdj_pkg::MONTH_W-1:0] i_month_in,
    input  logic [gdj_pkg::DAY_W-1:0]   i_day_in,
    input  logic [gdj_pkg::JDN_W-1:0]   i_jdn_in,
    output logic                        o_strobe,
    output logic [gdj_pkg::JDN_W-1:0]   o_jdn_out,
    output logic [gdj_pkg::YEAR_W-1:0]  o_year_out,
    output logic [gdj_pkg::MONTH_W-1:0] o_month_out,
    output logic [gdj_pkg::DAY_W-1:0]   o_day_out,
    output logic                        o_valid_res,
    output logic                        o_leap_year,
    output logic [gdj_pkg::DAY_W-1:0]   o_month_days
);
    import gdj_pkg::*;

    typedef struct packed {
        logic               req;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [JDN_W-1:0]   jdn;
    } t_echo;

    typedef struct packed {
        logic               req;
        logic               rng;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [JDN_W-1:0]   jdn;
        logic [26:0]        qprod;
    } t_tail;

    // Every cycle is open for a new beat
    logic n_take;

    assign busy   = 1'b0;
    assign n_take = start & ~busy;

    // Conversion cores
    logic [JDN_W-1:0] w_d2j_jdn;
    t_date            w_j2d_date;
    logic             w_j2d_rng;

    gdj_d2j u_d2j (
        .i_clk   (i_clk),
        .i_year  (i_year_in),
        .i_month (i_month_in),
        .i_day   (i_day_in),
        .o_jdn   (w_d2j_jdn)
    );

    gdj_j2d u_j2d (
        .i_clk  (i_clk),
        .i_jdn  (i_jdn_in),
        .o_date (w_j2d_date),
        .o_rng  (w_j2d_rng)
    );

    // Valid bits and request echo alongside the cores
    logic [PIPE_LAT-1:0] r_vld;
    t_echo               n_echo;
    t_echo               r_echo [0:PIPE_LAT-1];

    assign n_echo = '{req: i_req_type, year: i_year_in, month: i_month_in,
                      day: i_day_in, jdn: i_jdn_in};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], n_take};
        end
    end

    always_ff @(posedge i_clk) begin
        r_echo[0] <= n_echo;
    end

    for (genvar g = 1; g < PIPE_LAT; g++) begin : g_echo
        always_ff @(posedge i_clk) begin
            r_echo[g] <= r_echo[g-1];
        end
    end

    // Tail stage 1: pick the date for this direction, start the year / 100 divide
    t_echo w_echo;
    t_tail n_tail, r_tail;
    logic  r_tail_vld;

    assign w_echo = r_echo[PIPE_LAT-1];

    always_comb begin
        n_tail.req = w_echo.req;
        if (w_echo.req == REQ_J2D) begin
            n_tail.rng   = w_j2d_rng;
            n_tail.year  = w_j2d_date.year;
            n_tail.month = w_j2d_date.month;
            n_tail.day   = w_j2d_date.day;
            n_tail.jdn   = w_echo.jdn;
        end else begin
            n_tail.rng   = 1'b1;
            n_tail.year  = w_echo.year;
            n_tail.month = w_echo.month;
            n_tail.day   = w_echo.day;
            n_tail.jdn   = w_d2j_jdn;
        end
        n_tail.qprod = 27'(n_tail.year) * 27'(RECIP100_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_vld <= 1'b0;
        end else begin
            r_tail_vld <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tail <= n_tail;
    end

    // Tail stage 2: leap year, month length, validity and masking
    logic [7:0]         n_q100;
    logic [13:0]        n_yrem;
    logic               n_leap;
    logic [DAY_W-1:0]   n_mdays;
    logic               n_ok;
    logic [JDN_W-1:0]   n_jdn_out;
    logic [YEAR_W-1:0]  n_year_out;
    logic [MONTH_W-1:0] n_month_out;
    logic [DAY_W-1:0]   n_day_out;
    logic               n_leap_out;
    logic [DAY_W-1:0]   n_mdays_out;

    always_comb begin
        n_q100  = r_tail.qprod[26:RECIP100_SH];
        n_yrem  = r_tail.year - (14'(n_q100) * 14'd100);
        n_leap  = (r_tail.year[1:0] == 2'b00) &&
                  ((n_yrem[6:0] != 7'd0) || (n_q100[1:0] == 2'b00));
        n_mdays = f_month_len(r_tail.month, n_leap);

        if (r_tail.req == REQ_J2D) begin
            n_ok = r_tail.rng;
        end else begin
            n_ok = (r_tail.year >= 14'd1) && (r_tail.year <= 14'd9999) &&
                   (n_mdays != 5'd0) && (r_tail.day >= 5'd1) && (r_tail.day <= n_mdays);
        end

        n_jdn_out   = n_ok ? r_tail.jdn : '0;
        n_year_out  = r_tail.year;
        n_month_out = r_tail.month;
        n_day_out   = r_tail.day;
        n_leap_out  = n_leap;
        n_mdays_out = n_mdays;

        // Drop everything for a day number outside the supported range
        if ((r_tail.req == REQ_J2D) && !r_tail.rng) begin
            n_year_out  = '0;
            n_month_out = '0;
            n_day_out   = '0;
            n_leap_out  = 1'b0;
            n_mdays_out = '0;
        end
    end

    logic               r_strobe;
    logic [JDN_W-1:0]   r_jdn_out;
    logic [YEAR_W-1:0]  r_year_out;
    logic [MONTH_W-1:0] r_month_out;
    logic [DAY_W-1:0]   r_day_out;
    logic               r_valid_res;
    logic               r_leap_year;
    logic [DAY_W-1:0]   r_month_days;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_tail_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_jdn_out    <= n_jdn_out;
        r_year_out   <= n_year_out;
        r_month_out  <= n_month_out;
        r_day_out    <= n_day_out;
        r_valid_res  <= n_ok;
        r_leap_year  <= n_leap_out;
        r_month_days <= n_mdays_out;
    end

    assign o_strobe     = r_strobe;
    assign o_jdn_out    = r_jdn_out;
    assign o_year_out   = r_year_out;
    assign o_month_out  = r_month_out;
    assign o_day_out    = r_day_out;
    assign o_valid_res  = r_valid_res;
    assign o_leap_year  = r_leap_year;
    assign o_month_days = r_month_days;

    // Each result beat comes from a request taken a fixed latency earlier
    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LATENCY))
        else $error("result beat without a matching request");

    // A rejected request never reports a day number
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |-> (o_jdn_out == '0))
        else $error("day number reported for an invalid request");

    // A valid result carries a real calendar date
    a_valid_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_valid_res) |->
            ((o_month_out >= 4'd1) && (o_month_out <= 4'd12) &&
             (o_day_out >= 5'd1) && (o_day_out <= o_month_days)))
        else $error("valid result with an impossible date");

    // A valid result's day number lies in the supported range
    a_valid_jdn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_valid_res) |-> ((o_jdn_out >= JDN_MIN) && (o_jdn_out <= JDN_MAX)))
        else $error("valid result with a day number out of range");

endmodule

### rtl/gdj_d2j.sv
// Date to day number pipeline: five compute stages, padded to the core depth.
module gdj_d2j (
    input  logic                        i_clk,
    input  logic [gdj_pkg::YEAR_W-1:0]  i_year,
    input  logic [gdj_pkg::MONTH_W-1:0] i_month,
    input  logic [gdj_pkg::DAY_W-1:0]   i_day,
    output logic [gdj_pkg::JDN_W-1:0]   o_jdn
);
    import gdj_pkg::*;

    // Stage 1: move January and February to the end of the previous year
    logic                 n_late;
    logic [YEAR_W-1:0]    n_yy, r_yy_s1, r_yy_s2;
    logic [3:0]           n_mm, r_mm_s1, r_mm_s2, r_mm_s3;
    logic [DAY_W-1:0]     r_day_s1, r_day_s2, r_day_s3;

    assign n_late = (i_month >= 4'd3);
    assign n_mm   = n_late ? (i_month - 4'd3) : (i_month + 4'd9);
    assign n_yy   = n_late ? i_year : (i_year - 14'd1);

    always_ff @(posedge i_clk) begin
        r_yy_s1  <= n_yy;
        r_mm_s1  <= n_mm;
        r_day_s1 <= i_day;
    end

    // Stage 2: reciprocal multiply for the century
    logic [26:0] n_p, r_p_s2;

    assign n_p = 27'(r_yy_s1) * 27'(RECIP100_MUL);

    always_ff @(posedge i_clk) begin
        r_p_s2   <= n_p;
        r_yy_s2  <= r_yy_s1;
        r_mm_s2  <= r_mm_s1;
        r_day_s2 <= r_day_s1;
    end

    // Stage 3: century and year within the century
    logic [7:0]  n_cent, r_cent_s3;
    logic [13:0] n_yrem;
    logic [6:0]  n_yic, r_yic_s3;

    assign n_cent = r_p_s2[26:RECIP100_SH];
    assign n_yrem = r_yy_s2 - (14'(n_cent) * 14'd100);
    assign n_yic  = n_yrem[6:0];

    always_ff @(posedge i_clk) begin
        r_cent_s3 <= n_cent;
        r_yic_s3  <= n_yic;
        r_mm_s3   <= r_mm_s2;
        r_day_s3  <= r_day_s2;
    end

    // Stage 4: day counts of whole centuries, whole years and whole months
    logic [25:0] n_cprod;
    logic [23:0] r_t1_s4;
    logic [15:0] n_t2, r_t2_s4;
    logic [8:0]  n_t3, r_t3_s4;

    assign n_cprod = 26'(r_cent_s3) * 26'd146097;
    assign n_t2    = (16'(r_yic_s3) * 16'd365) + 16'(r_yic_s3[6:2]);
    assign n_t3    = f_days_before(r_mm_s3) + 9'(r_day_s3);

    always_ff @(posedge i_clk) begin
        r_t1_s4 <= n_cprod[25:2];
        r_t2_s4 <= n_t2;
        r_t3_s4 <= n_t3;
    end

    // Stage 5: add up with the epoch offset
    logic [23:0]      n_sum;
    logic [JDN_W-1:0] r_jdn_d [0:D2J_PAD];

    assign n_sum = r_t1_s4 + 24'(r_t2_s4) + 24'(r_t3_s4) + 24'd1721119;

    always_ff @(posedge i_clk) begin
        r_jdn_d[0] <= n_sum[JDN_W-1:0];
    end

    // Pad to the depth of the day number path
    for (genvar g = 1; g <= D2J_PAD; g++) begin : g_pad
        always_ff @(posedge i_clk) begin
            r_jdn_d[g] <= r_jdn_d[g-1];
        end
    end

    assign o_jdn = r_jdn_d[D2J_PAD];

endmodule

### rtl/gdj_j2d.sv
// Day number to date pipeline: two reciprocal divides with correction and a month search.
module gdj_j2d (
    input  logic                      i_clk,
    input  logic [gdj_pkg::JDN_W-1:0] i_jdn,
    output gdj_pkg::t_date            o_date,
    output logic                      o_rng
);
    import gdj_pkg::*;

    // Range flag travels with the data
    logic                n_rng;
    logic [PIPE_LAT-1:0] r_rng;

    assign n_rng = (i_jdn >= JDN_MIN) && (i_jdn <= JDN_MAX);

    always_ff @(posedge i_clk) begin
        r_rng <= {r_rng[PIPE_LAT-2:0], n_rng};
    end

    assign o_rng = r_rng[PIPE_LAT-1];

    // Stage 1: quarter-day count from the March epoch
    logic [24:0] n_asum;
    logic [23:0] r_a_s1, r_a_s2;

    assign n_asum = {i_jdn, 2'b00} - 25'd6884477;

    always_ff @(posedge i_clk) begin
        r_a_s1 <= n_asum[23:0];
    end

    // Stage 2: estimate the century by reciprocal multiply
    logic [32:0] n_p1, r_p1_s2;

    assign n_p1 = 33'(r_a_s1) * 33'd459;

    always_ff @(posedge i_clk) begin
        r_p1_s2 <= n_p1;
        r_a_s2  <= r_a_s1;
    end

    // Stage 3: remainder of the estimate, short by at most one divisor
    logic [6:0]  n_q0, r_q0_s3;
    logic [24:0] n_qprod;
    logic [23:0] n_adiff;
    logic [18:0] r_rem0_s3;

    assign n_q0    = r_p1_s2[32:26];
    assign n_qprod = 25'(n_q0) * 25'd146097;
    assign n_adiff = r_a_s2 - n_qprod[23:0];

    always_ff @(posedge i_clk) begin
        r_q0_s3   <= n_q0;
        r_rem0_s3 <= n_adiff[18:0];
    end

    // Stage 4: correct the century, round the remainder up to 4k+3
    logic [6:0]  n_cent;
    logic [18:0] n_rsub;
    logic [17:0] n_r, n_u, r_u_s4, r_u_s5;
    logic [6:0]  r_cent [0:4];

    always_comb begin
        n_rsub = r_rem0_s3 - 19'd146097;
        if (r_rem0_s3 >= 19'd146097) begin
            n_cent = r_q0_s3 + 7'd1;
            n_r    = n_rsub[17:0];
        end else begin
            n_cent = r_q0_s3;
            n_r    = r_rem0_s3[17:0];
        end
    end

    assign n_u = {n_r[17:2], 2'b11};

    always_ff @(posedge i_clk) begin
        r_cent[0] <= n_cent;
        r_u_s4    <= n_u;
    end

    // Carry the century down to the last stage
    for (genvar g = 1; g < 5; g++) begin : g_cent
        always_ff @(posedge i_clk) begin
            r_cent[g] <= r_cent[g-1];
        end
    end

    // Stage 5: estimate the year within the century
    logic [31:0] n_p2, r_p2_s5;

    assign n_p2 = 32'(r_u_s4) * 32'd11483;

    always_ff @(posedge i_clk) begin
        r_p2_s5 <= n_p2;
        r_u_s5  <= r_u_s4;
    end

    // Stage 6: remainder of the year estimate
    logic [6:0]  n_yq0, r_yq0_s6;
    logic [17:0] n_yprod, n_vdiff;
    logic [11:0] r_v0_s6;

    assign n_yq0   = r_p2_s5[30:24];
    assign n_yprod = 18'(n_yq0) * 18'd1461;
    assign n_vdiff = r_u_s5 - n_yprod;

    always_ff @(posedge i_clk) begin
        r_yq0_s6 <= n_yq0;
        r_v0_s6  <= n_vdiff[11:0];
    end

    // Stage 7: correct the year, day within the March-based year
    logic [6:0]  n_yic, r_yic_s7, r_yic_s8;
    logic [11:0] n_vsub;
    logic [10:0] n_v;
    logic [8:0]  r_e_s7, r_e_s8;

    always_comb begin
        n_vsub = r_v0_s6 - 12'd1461;
        if (r_v0_s6 >= 12'd1461) begin
            n_yic = r_yq0_s6 + 7'd1;
            n_v   = n_vsub[10:0];
        end else begin
            n_yic = r_yq0_s6;
            n_v   = r_v0_s6[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_yic_s7 <= n_yic;
        r_e_s7   <= n_v[10:2];
    end

    // Stage 8: month search against the month start table
    logic [3:0] n_mm, r_mm_s8;

    always_comb begin
        n_mm = '0;
        for (int k = 1; k < MONTHS; k++) begin
            if (r_e_s7 >= f_days_before(4'(k))) begin
                n_mm = n_mm + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mm_s8  <= n_mm;
        r_e_s8   <= r_e_s7;
        r_yic_s8 <= r_yic_s7;
    end

    // Stage 9: back to calendar month, day and year
    logic       n_carry;
    logic [8:0] n_dd;
    t_date      n_date, r_date;

    always_comb begin
        n_carry      = (r_mm_s8 >= 4'd10);
        n_dd         = r_e_s8 - f_days_before(r_mm_s8);
        n_date.day   = n_dd[DAY_W-1:0] + 5'd1;
        n_date.month = n_carry ? (r_mm_s8 - 4'd9) : (r_mm_s8 + 4'd3);
        n_date.year  = (14'(r_cent[4]) * 14'd100) + 14'(r_yic_s8) + 14'(n_carry);
    end

    always_ff @(posedge i_clk) begin
        r_date <= n_date;
    end

    assign o_date = r_date;

endmodule
